@@ src/atr_pkg.sv @@
package atr_pkg;

  // table geometry and limits
  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int SEQ_W = 32;
  localparam int TIME_W = 48;
  localparam int RETRY_W = 4;
  localparam int BASE_W = 16;
  localparam int WAIT_W = BASE_W + RETRY_W + 1;

  // configuration reset values
  localparam logic [BASE_W-1:0] BASE_TIMEOUT_RST = 16'd2000;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd5;

  // configuration register indexes
  localparam logic CFG_BASE_TIMEOUT = 1'b0;
  localparam logic CFG_MAX_RETRIES = 1'b1;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_ACK      = 2'd1,
    OP_SCAN     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_REGISTERED  = 3'd0,
    KIND_FULL        = 3'd1,
    KIND_ACKED       = 3'd2,
    KIND_ACK_UNKNOWN = 3'd3,
    KIND_RETRANSMIT  = 3'd4,
    KIND_DROPPED     = 3'd5,
    KIND_NOTHING_DUE = 3'd6
  } kind_t;

  // one table entry as it travels around the ring
  typedef struct packed {
    logic               valid;
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  sent_time;
    logic [RETRY_W-1:0] retries;
  } entry_t;

  // one result item
  typedef struct packed {
    kind_t              kind;
    logic [SEQ_W-1:0]   seq;
    logic [RETRY_W-1:0] attempt;
  } res_t;

  // what the head unit saw at the entry passing it
  typedef struct packed {
    logic matched;
    logic is_free;
    logic scan_hit;
  } head_stat_t;

endpackage

@@ src/ack_retransmit_tracker.sv @@
// Retransmission tracker for unacknowledged requests, linear backoff.
// Input channel (in_valid/in_ready) takes one beat with op, seq_num and
// now_time: register a sent request, acknowledge/cancel it, or scan for expiry.
// Output channel (out_valid/out_ready) gives result beats: kind, out_seq,
// attempt and last; last marks the final result of an input beat.
// The table is a ring of TABLE_DEPTH cells that rotates one place per cycle
// past a single head unit, so each item walks the whole ring in index order.
// Acknowledge and scan make one lap of the ring before their final result;
// register makes a search lap and, if it finds a slot, a write lap. One item
// is worked on at a time; the next is accepted in the cycle after the final
// result is loaded. op 3 is consumed with no result. A scan gives up to 16
// results, one per due entry, at most one per cycle. When the receiver stalls,
// the ring stops rotating while a result waits; the output register keeps the
// waiting beat steady until it is taken. Reset empties the table at once (no
// clearing pass) and sets base_timeout to 2000 and max_retries to 5; cfg_we
// writes register cfg_index; the user must do so only when idle (not enforced).
module ack_retransmit_tracker #(
  parameter int TABLE_DEPTH = atr_pkg::TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [atr_pkg::BASE_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [atr_pkg::SEQ_W-1:0]    seq_num,
  input  logic [atr_pkg::TIME_W-1:0]   now_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   kind,
  output logic [atr_pkg::SEQ_W-1:0]    out_seq,
  output logic [atr_pkg::RETRY_W-1:0]  attempt,
  output logic                         last
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FINISH
  } state_t;

  state_t                         state;
  atr_pkg::op_t                   op_q;
  logic [atr_pkg::SEQ_W-1:0]      seq_q;
  logic [atr_pkg::TIME_W-1:0]     now_q;
  logic                           phase;
  logic [IDX_W-1:0]               step;
  logic [IDX_W-1:0]               tgt;
  logic                           tgt_found;
  logic                           tgt_match;
  logic                           hit;
  logic [atr_pkg::CNT_W-1:0]      count;
  logic                           pend_valid;
  atr_pkg::res_t                  pend;
  logic [atr_pkg::BASE_W-1:0]     base_timeout;
  logic [atr_pkg::RETRY_W-1:0]    max_retries;

  atr_pkg::entry_t                ring [TABLE_DEPTH];
  atr_pkg::entry_t                head_nxt;
  atr_pkg::head_stat_t            stat;
  atr_pkg::res_t                  scan_res;

  logic                           out_free;
  logic                           push;
  logic                           stall;
  logic                           shift;
  logic                           write_here;
  logic                           room;
  logic                           fin_emit;
  atr_pkg::res_t                  fin_res;

  assign in_ready   = (state == ST_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign write_here = (op_q == atr_pkg::OP_REGISTER) && phase && (step == tgt);
  assign room       = count < atr_pkg::CNT_W'(atr_pkg::MAX_RESULTS);
  assign push       = (state == ST_PASS) && stat.scan_hit && pend_valid;
  assign stall      = push && !out_free;
  assign shift      = (state == ST_PASS) && !stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_timeout <= atr_pkg::BASE_TIMEOUT_RST;
      max_retries  <= atr_pkg::MAX_RETRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atr_pkg::CFG_BASE_TIMEOUT: base_timeout <= cfg_data;
        atr_pkg::CFG_MAX_RETRIES:  max_retries  <= cfg_data[atr_pkg::RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ring of entry cells, head output re-enters at the tail
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == TABLE_DEPTH - 1) begin : g_tail
        atr_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .d     (head_nxt),
          .q     (ring[gi])
        );
      end else begin : g_mid
        atr_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .d     (ring[gi+1]),
          .q     (ring[gi])
        );
      end
    end
  endgenerate

  // head unit works on the entry in cell 0
  atr_head u_head (
    .cur          (ring[0]),
    .op           (op_q),
    .seq          (seq_q),
    .now          (now_q),
    .base_timeout (base_timeout),
    .max_retries  (max_retries),
    .write_here   (write_here),
    .room         (room),
    .nxt          (head_nxt),
    .stat         (stat),
    .res          (scan_res)
  );

  // final result of the item
  always_comb begin
    fin_emit     = 1'b1;
    fin_res.kind = atr_pkg::KIND_NOTHING_DUE;
    fin_res.seq  = seq_q;
    fin_res.attempt = '0;
    case (op_q)
      atr_pkg::OP_REGISTER: begin
        if (!phase && tgt_found) begin
          fin_emit = 1'b0;
        end
        fin_res.kind = phase ? atr_pkg::KIND_REGISTERED : atr_pkg::KIND_FULL;
      end
      atr_pkg::OP_ACK: begin
        fin_res.kind = hit ? atr_pkg::KIND_ACKED : atr_pkg::KIND_ACK_UNKNOWN;
      end
      default: begin
        if (pend_valid) begin
          fin_res = pend;
        end else begin
          fin_res.seq = '0;
        end
      end
    endcase
  end

  // sequencer, pass bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q       <= atr_pkg::op_t'(op);
            seq_q      <= seq_num;
            now_q      <= now_time;
            phase      <= 1'b0;
            step       <= '0;
            tgt_found  <= 1'b0;
            tgt_match  <= 1'b0;
            hit        <= 1'b0;
            count      <= '0;
            pend_valid <= 1'b0;
            if (op != atr_pkg::OP_NONE) begin
              state <= ST_PASS;
            end
          end
        end
        ST_PASS: begin
          if (shift) begin
            step <= step + 1'b1;
            if (step == LAST_STEP) begin
              step  <= '0;
              state <= ST_FINISH;
            end
            // search lap of a register: a match beats the lowest free slot
            if (op_q == atr_pkg::OP_REGISTER && !phase) begin
              if (stat.matched && !tgt_match) begin
                tgt       <= step;
                tgt_found <= 1'b1;
                tgt_match <= 1'b1;
              end else if (stat.is_free && !tgt_found) begin
                tgt       <= step;
                tgt_found <= 1'b1;
              end
            end
            if (op_q == atr_pkg::OP_ACK && stat.matched) begin
              hit <= 1'b1;
            end
            // scan results go through one pending stage to learn last
            if (stat.scan_hit) begin
              count      <= count + 1'b1;
              pend       <= scan_res;
              pend_valid <= 1'b1;
              if (pend_valid) begin
                out_valid <= 1'b1;
                kind      <= pend.kind;
                out_seq   <= pend.seq;
                attempt   <= pend.attempt;
                last      <= 1'b0;
              end
            end
          end
        end
        ST_FINISH: begin
          if (!fin_emit) begin
            phase <= 1'b1;
            state <= ST_PASS;
          end else if (out_free) begin
            out_valid <= 1'b1;
            kind      <= fin_res.kind;
            out_seq   <= fin_res.seq;
            attempt   <= fin_res.attempt;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/atr_cell.sv @@
module atr_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  atr_pkg::entry_t   d,
  output atr_pkg::entry_t   q
);

  // valid bit, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= d.valid;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (shift) begin
      q.seq       <= d.seq;
      q.sent_time <= d.sent_time;
      q.retries   <= d.retries;
    end
  end

endmodule

@@ src/atr_head.sv @@
module atr_head (
  input  atr_pkg::entry_t                   cur,
  input  atr_pkg::op_t                      op,
  input  logic [atr_pkg::SEQ_W-1:0]         seq,
  input  logic [atr_pkg::TIME_W-1:0]        now,
  input  logic [atr_pkg::BASE_W-1:0]        base_timeout,
  input  logic [atr_pkg::RETRY_W-1:0]       max_retries,
  input  logic                              write_here,
  input  logic                              room,
  output atr_pkg::entry_t                   nxt,
  output atr_pkg::head_stat_t               stat,
  output atr_pkg::res_t                     res
);

  logic [atr_pkg::TIME_W-1:0]  elapsed;
  logic [atr_pkg::WAIT_W-1:0]  wait_time;
  logic [atr_pkg::RETRY_W-1:0] retries_inc;
  logic                        expired;

  // expiry test with linear backoff
  assign elapsed     = now - cur.sent_time;
  assign wait_time   = atr_pkg::WAIT_W'(base_timeout) *
                       atr_pkg::WAIT_W'({1'b0, cur.retries} + 5'd1);
  assign expired     = elapsed >= atr_pkg::TIME_W'(wait_time);
  assign retries_inc = cur.retries + 4'd1;

  // per-entry update
  always_comb begin
    nxt           = cur;
    stat.matched  = cur.valid && (cur.seq == seq);
    stat.is_free  = !cur.valid;
    stat.scan_hit = 1'b0;
    res.kind      = atr_pkg::KIND_DROPPED;
    res.seq       = cur.seq;
    res.attempt   = '0;
    case (op)
      atr_pkg::OP_REGISTER: begin
        if (write_here) begin
          nxt.valid     = 1'b1;
          nxt.seq       = seq;
          nxt.sent_time = now;
          nxt.retries   = '0;
        end
      end
      atr_pkg::OP_ACK: begin
        if (stat.matched) begin
          nxt.valid = 1'b0;
        end
      end
      atr_pkg::OP_SCAN: begin
        if (cur.valid && room && expired) begin
          stat.scan_hit = 1'b1;
          if (cur.retries >= max_retries) begin
            nxt.valid = 1'b0;
          end else begin
            nxt.retries   = retries_inc;
            nxt.sent_time = now;
            res.kind      = atr_pkg::KIND_RETRANSMIT;
            res.attempt   = retries_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sim/atr_checker.sv @@
`timescale 1ns / 1ps

module atr_checker
  import atr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [BASE_W-1:0]  cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         op,
  input  logic [SEQ_W-1:0]   seq_num,
  input  logic [TIME_W-1:0]  now_time,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         kind,
  input  logic [SEQ_W-1:0]   out_seq,
  input  logic [RETRY_W-1:0] attempt,
  input  logic               last,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    kind_t              kind;
    logic [SEQ_W-1:0]   seq;
    logic [RETRY_W-1:0] attempt;
    logic               last;
  } outcome_t;

  // shadow of the retransmit table and its settings
  logic               slot_used  [TABLE_DEPTH];
  logic [SEQ_W-1:0]   slot_seq   [TABLE_DEPTH];
  logic [TIME_W-1:0]  slot_time  [TABLE_DEPTH];
  logic [RETRY_W-1:0] slot_tries [TABLE_DEPTH];
  logic [BASE_W-1:0]  base_to;
  logic [RETRY_W-1:0] retry_limit;

  // results still owed by the block, oldest first
  outcome_t awaited_results[$];

  function automatic int find_slot(logic [SEQ_W-1:0] s);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_used[i] && slot_seq[i] == s) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t make_outcome(kind_t k, logic [SEQ_W-1:0] s,
                                            logic [RETRY_W-1:0] a, logic l);
    outcome_t r;
    r.kind = k;
    r.seq = s;
    r.attempt = a;
    r.last = l;
    return r;
  endfunction

  // append one owed result at the young end
  function automatic void owe_result(outcome_t r);
    awaited_results = {awaited_results, r};
  endfunction

  // update the shadow table for one request beat and queue its results
  task automatic track_request(op_t o, logic [SEQ_W-1:0] s, logic [TIME_W-1:0] t);
    int idx;
    int hits;
    logic [TIME_W-1:0] elapsed;
    logic [WAIT_W-1:0] span;
    outcome_t held;
    case (o)
      OP_REGISTER: begin
        idx = find_slot(s);
        // new sequence number takes the lowest free slot
        if (idx < 0) begin
          for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!slot_used[i]) idx = i;
          end
        end
        if (idx < 0) begin
          owe_result(make_outcome(KIND_FULL, s, '0, 1'b1));
        end else begin
          slot_used[idx] = 1'b1;
          slot_seq[idx] = s;
          slot_time[idx] = t;
          slot_tries[idx] = '0;
          owe_result(make_outcome(KIND_REGISTERED, s, '0, 1'b1));
        end
      end
      OP_ACK: begin
        idx = find_slot(s);
        if (idx < 0) begin
          owe_result(make_outcome(KIND_ACK_UNKNOWN, s, '0, 1'b1));
        end else begin
          slot_used[idx] = 1'b0;
          owe_result(make_outcome(KIND_ACKED, s, '0, 1'b1));
        end
      end
      OP_SCAN: begin
        hits = 0;
        // each result is held back one step so the final one can carry last
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot_used[i] && hits < MAX_RESULTS) begin
            elapsed = t - slot_time[i];
            span = base_to * (slot_tries[i] + 1'b1);
            if (elapsed >= span) begin
              if (hits > 0) owe_result(held);
              if (slot_tries[i] >= retry_limit) begin
                slot_used[i] = 1'b0;
                held = make_outcome(KIND_DROPPED, slot_seq[i], '0, 1'b0);
              end else begin
                slot_tries[i] = slot_tries[i] + 1'b1;
                slot_time[i] = t;
                held = make_outcome(KIND_RETRANSMIT, slot_seq[i], slot_tries[i], 1'b0);
              end
              hits++;
            end
          end
        end
        if (hits == 0) begin
          owe_result(make_outcome(KIND_NOTHING_DUE, '0, '0, 1'b1));
        end else begin
          held.last = 1'b1;
          owe_result(held);
        end
      end
      default: ;
    endcase
  endtask

  // compare one result beat with the oldest owed result
  task automatic check_result();
    outcome_t want;
    if (awaited_results.size() == 0) begin
      if (mismatches < 10)
        $display("result beat with nothing owed: kind %0d seq %h attempt %0d last %b",
                 kind, out_seq, attempt, last);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      if (kind !== want.kind || out_seq !== want.seq || attempt !== want.attempt ||
          last !== want.last) begin
        if (mismatches < 10)
          $display("mismatch: want %0d %h %0d %b, got %0d %h %0d %b",
                   want.kind, want.seq, want.attempt, want.last,
                   kind, out_seq, attempt, last);
        mismatches++;
      end
    end
  endtask

  // sample both channels and the config port at each edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      base_to = BASE_TIMEOUT_RST;
      retry_limit = MAX_RETRIES_RST;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE_TIMEOUT) base_to = cfg_data;
        else retry_limit = cfg_data[RETRY_W-1:0];
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) track_request(op_t'(op), seq_num, now_time);
    end
    outstanding <= awaited_results.size();
  end

endmodule

@@ sim/tb_ack_retransmit_tracker.sv @@
`timescale 1ns / 1ps

module tb_ack_retransmit_tracker;
  import atr_pkg::*;

  localparam int SETTLE = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [BASE_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op = '0;
  logic [SEQ_W-1:0]   seq_num = '0;
  logic [TIME_W-1:0]  now_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         kind;
  logic [SEQ_W-1:0]   out_seq;
  logic [RETRY_W-1:0] attempt;
  logic               last;

  int mismatches;
  int outstanding;

  // stimulus shaping shared with the result sink
  bit no_idle = 1'b0;
  int long_hold = 0;

  logic [TIME_W-1:0] now_ms;
  logic [SEQ_W-1:0]  seq_pool[24];

  ack_retransmit_tracker dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .seq_num(seq_num), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_seq(out_seq), .attempt(attempt), .last(last)
  );

  atr_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .seq_num(seq_num), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_seq(out_seq), .attempt(attempt), .last(last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("tb_ack_retransmit_tracker: done, errors");
    $finish;
  end

  // result sink with random stalls and an occasional long hold-off
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // offer one request beat after a random gap, return once accepted
  task automatic send_item(op_t o, logic [SEQ_W-1:0] s, logic [TIME_W-1:0] t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    seq_num <= s;
    now_time <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // stop offering and wait until every owed result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write both timing registers on back-to-back edges
  task automatic set_timing(logic [BASE_W-1:0] base, logic [RETRY_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE_TIMEOUT;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= CFG_MAX_RETRIES;
    cfg_data <= BASE_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly register/ack of pooled sequence numbers under a drifting clock
  task automatic random_item(logic [BASE_W-1:0] base);
    int pick;
    op_t o;
    logic [SEQ_W-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 45) o = OP_REGISTER;
    else if (pick < 80) o = OP_ACK;
    else if (pick < 95) o = OP_SCAN;
    else o = OP_NONE;
    s = ($urandom_range(0, 9) == 0) ? $urandom : seq_pool[$urandom_range(0, 23)];
    if ($urandom_range(0, 49) == 0) now_ms = TIME_W'({$urandom, $urandom});
    else now_ms = now_ms + TIME_W'($urandom_range(0, 3 * int'(base) + 4));
    send_item(o, s, now_ms);
  endtask

  task automatic run_phase(int count, logic [BASE_W-1:0] base);
    seq_pool[0] = '0;
    seq_pool[1] = '1;
    for (int i = 2; i < 24; i++) seq_pool[i] = $urandom;
    now_ms = TIME_W'({$urandom, $urandom});
    for (int n = 0; n < count; n++) random_item(base);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty scan, unknown ack, duplicate, time wrap, full table
    send_item(OP_SCAN, $urandom, '0);
    send_item(OP_ACK, '0, '0);
    send_item(OP_REGISTER, '0, '0);
    send_item(OP_REGISTER, '1, '1);
    send_item(OP_REGISTER, '0, 48'd100);
    send_item(OP_NONE, $urandom, TIME_W'({$urandom, $urandom}));
    send_item(OP_SCAN, $urandom, 48'd50);
    send_item(OP_ACK, '1, 48'd60);
    send_item(OP_ACK, '1, 48'd70);
    for (int i = 1; i < TABLE_DEPTH; i++) send_item(OP_REGISTER, SEQ_W'(i), 48'd1000);
    send_item(OP_REGISTER, 32'hA5A5_A5A5, 48'd1000);
    send_item(OP_SCAN, '0, 48'h7FFF_FFFF_FFFF);

    // reset settings, with a long sink hold-off, a pause and a no-idle stretch
    seq_pool[0] = '0;
    seq_pool[1] = '1;
    for (int i = 2; i < 24; i++) seq_pool[i] = $urandom;
    now_ms = TIME_W'({$urandom, $urandom});
    for (int n = 0; n < 104; n++) begin
      if (n == 10) long_hold = 300;
      if (n == 40) drain();
      no_idle = (n >= 45 && n < 65);
      random_item(BASE_TIMEOUT_RST);
    end
    no_idle = 1'b0;

    // settings sweep: extremes, zero timeout, a moderate setting, random
    drain();
    set_timing(16'd1, 4'd0);
    run_phase(60, 16'd1);
    drain();
    set_timing(16'hFFFF, 4'd15);
    run_phase(60, 16'hFFFF);
    drain();
    set_timing(16'd0, 4'd7);
    run_phase(50, 16'd0);
    drain();
    set_timing(16'd20, 4'd3);
    run_phase(60, 16'd20);
    begin
      logic [BASE_W-1:0] rnd_base;
      rnd_base = BASE_W'($urandom_range(1, 65535));
      drain();
      set_timing(rnd_base, RETRY_W'($urandom_range(0, 15)));
      run_phase(60, rnd_base);
    end

    // wait out the last results
    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_ack_retransmit_tracker: done, clean");
    end else begin
      $display("tb_ack_retransmit_tracker: done, errors");
    end
    $finish;
  end

endmodule
